[hdl/i2cbb_pkg.sv]
// shared types, constants and helpers for the bit-banged i2c master sequencer
// no dependencies
package i2cbb_pkg;

    localparam int DELAY_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int PHASE_WIDTH = 6;

    localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 16'd5;

    // op codes of an input word
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // command held while a sequence runs
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic       sda_in;
        logic       send_ack;
        logic [7:0] data_byte;
    } item_t;

    // packed so that scl_level sits in bit 0
    typedef struct packed {
        logic       cmd_dropped;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } result_t;

    function automatic logic [PHASE_WIDTH-1:0] action_count(input logic [1:0] cmd);
        logic [PHASE_WIDTH-1:0] n;
        case (cmd)
            CMD_START: n = 6'd3;
            CMD_STOP:  n = 6'd2;
            CMD_WRITE: n = 6'd27;
            default:   n = 6'd18;
        endcase
        return n;
    endfunction

    // step within a write bit: k mod 3, via k*11 >> 5 for k below 32
    function automatic logic [1:0] write_sub(input logic [PHASE_WIDTH-1:0] k);
        logic [8:0]             p;
        logic [3:0]             b;
        logic [PHASE_WIDTH-1:0] r;
        p = 9'(k[4:0]) * 9'd11;
        b = p[8:5];
        r = k - 6'({b, 1'b0}) - 6'(b);
        return r[1:0];
    endfunction

endpackage

[hdl/i2cbb_seq.sv]
// pin sequencer state and next-state logic for one word per cycle while en is high
// depends on i2cbb_pkg
module i2cbb_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  i2cbb_pkg::item_t                item,
    input  logic [i2cbb_pkg::CFG_WIDTH-1:0] delay_ticks,
    output i2cbb_pkg::result_t              res
);

    logic [i2cbb_pkg::PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [1:0]                        cmd_reg, cmd_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [i2cbb_pkg::DELAY_WIDTH-1:0] dcnt_reg, dcnt_next;
    logic                              ack_reg, ack_next;
    logic                              scl_reg, scl_next;
    logic                              sda_reg, sda_next;
    logic [7:0]                        last_reg, last_next;

    logic [i2cbb_pkg::DELAY_WIDTH-1:0] dly;
    logic [i2cbb_pkg::DELAY_WIDTH-1:0] reload;
    logic [i2cbb_pkg::DELAY_WIDTH-1:0] dcnt_dec;
    logic                              is_cmd;
    logic                              start;
    logic                              perf;
    logic                              done;
    logic                              dropped;
    logic [1:0]                        act;
    logic [7:0]                        sh;
    logic                              ack_eff;
    logic [i2cbb_pkg::PHASE_WIDTH-1:0] k;

    assign dly      = i2cbb_pkg::DELAY_WIDTH'(delay_ticks);
    assign reload   = (dly == '0) ? i2cbb_pkg::DELAY_WIDTH'(1) : dly;
    assign dcnt_dec = dcnt_reg - i2cbb_pkg::DELAY_WIDTH'(1);
    assign is_cmd   = (item.op == i2cbb_pkg::OP_START) || (item.op == i2cbb_pkg::OP_STOP) ||
                      (item.op == i2cbb_pkg::OP_WRITE) || (item.op == i2cbb_pkg::OP_READ);

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        shift_next = shift_reg;
        dcnt_next  = dcnt_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        last_next  = last_reg;
        start      = 1'b0;
        perf       = 1'b0;
        done       = 1'b0;
        dropped    = 1'b0;

        if (en) begin
            if (is_cmd) begin
                if (phase_reg != '0) begin
                    dropped = 1'b1;
                end else begin
                    start = 1'b1;
                    perf  = 1'b1;
                end
            end else if (phase_reg != '0) begin
                dcnt_next = dcnt_dec;
                if (dcnt_dec == '0) begin
                    if (phase_reg >= i2cbb_pkg::action_count(cmd_reg)) begin
                        if (cmd_reg == i2cbb_pkg::CMD_READ) begin
                            last_next = shift_reg;
                        end
                        phase_next = '0;
                        done       = 1'b1;
                    end else begin
                        perf = 1'b1;
                    end
                end
            end
        end

        // operands of the pin action, fresh on a new command
        act     = start ? 2'(item.op - i2cbb_pkg::OP_START) : cmd_reg;
        sh      = start ? ((item.op == i2cbb_pkg::OP_WRITE) ? item.data_byte : 8'd0)
                        : shift_reg;
        ack_eff = start ? item.send_ack : ack_reg;
        k       = start ? '0 : phase_reg;

        if (perf) begin
            case (act)
                i2cbb_pkg::CMD_START: begin
                    if (k == 6'd0) begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end else if (k == 6'd1) begin
                        sda_next = 1'b0;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                i2cbb_pkg::CMD_STOP: begin
                    if (k == 6'd0) begin
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end else begin
                        sda_next = 1'b1;
                    end
                end
                i2cbb_pkg::CMD_WRITE: begin
                    case (i2cbb_pkg::write_sub(k))
                        2'd0: begin
                            if (k < 6'd24) begin
                                sda_next = sh[7];
                                sh       = {sh[6:0], 1'b0};
                            end else begin
                                sda_next = 1'b1;
                            end
                        end
                        2'd1: scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                default: begin
                    if (!k[0]) begin
                        if (k < 6'd16) begin
                            if (k < 6'd2) begin
                                sda_next = 1'b1;
                            end
                            sh = {sh[6:0], item.sda_in};
                        end else begin
                            sda_next = !ack_eff;
                        end
                        scl_next = 1'b1;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
            endcase
            shift_next = sh;
            cmd_next   = act;
            ack_next   = ack_eff;
            phase_next = k + i2cbb_pkg::PHASE_WIDTH'(1);
            dcnt_next  = reload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            cmd_reg   <= i2cbb_pkg::CMD_START;
            shift_reg <= '0;
            dcnt_reg  <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            last_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            shift_reg <= shift_next;
            dcnt_reg  <= dcnt_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        res.scl_level   = scl_next;
        res.sda_release = sda_next;
        res.busy_res    = (phase_next != '0);
        res.done_res    = done;
        res.read_byte   = last_next;
        res.cmd_dropped = dropped;
    end

endmodule

[hdl/i2c_bit_bang_master.sv]
// bit-banged i2c master: input word register, sequencer, result word register
// path: a word is held in the input word register, and its result word in the result word register
// throughput: one word per cycle while the result side does not hold off m_tready
// reset: both lines high, sequencer idle, delay_ticks 5, no words held
// depends on i2cbb_pkg and i2cbb_seq
module i2c_bit_bang_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], send_ack[8], sda_in[9], zero pad
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level[0], sda_release[1], busy_res[2], done_res[3], read_byte[11:4],
    // cmd_dropped[12], zero pad
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                            in_valid_reg;
    i2cbb_pkg::item_t                item_reg;
    logic                            out_valid_reg;
    i2cbb_pkg::result_t              out_reg;
    logic [i2cbb_pkg::CFG_WIDTH-1:0] delay_reg;
    i2cbb_pkg::result_t              res;
    logic                            adv;
    logic                            fire;

    assign adv       = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && adv;
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= i2cbb_pkg::DELAY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            delay_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op        <= s_tuser;
            item_reg.data_byte <= s_tdata[7:0];
            item_reg.send_ack  <= s_tdata[8];
            item_reg.sda_in    <= s_tdata[9];
        end
    end

    i2cbb_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (fire),
        .item        (item_reg),
        .delay_ticks (delay_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

`ifndef NO_ASSERTIONS
    // a finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_reg.done_res && out_reg.busy_res))
        else $error("done reported while still busy");

    // a dropped command never advances the sequence to completion
    a_drop_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_reg.done_res && out_reg.cmd_dropped))
        else $error("dropped command and done in the same word");

    // a word waiting in the input register moves on whenever the output side frees up
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("pending word not passed to the output register");
`endif

endmodule

[dv/tb.sv]
// testbench for i2c_bit_bang_master: directed table, then random command and tick streams
// checks every result word against the table value for a typed row, else against an in-bench copy of the pin sequencer
// depends on i2cbb_pkg and the i2c_bit_bang_master rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // op codes the block treats as a plain tick
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int N_ROWS = 21;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic        ack;
        logic        sda;
        logic [7:0]  reps;
        logic        typed;
        logic [15:0] want;
    } stim_row_t;

    // want layout: scl_level[0], sda_release[1], busy_res[2], done_res[3],
    // read_byte[11:4], cmd_dropped[12]
    stim_row_t stim_rows [0:N_ROWS-1] = '{
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd1,   1'b1, 16'h0003},
        '{OP_RSVD_5,           8'h00, 1'b0, 1'b0, 8'd1,   1'b1, 16'h0003},
        '{i2cbb_pkg::OP_START, 8'h00, 1'b0, 1'b0, 8'd1,   1'b1, 16'h0007},
        '{i2cbb_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, 8'd1,   1'b1, 16'h1007},
        '{i2cbb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 8'd1,   1'b1, 16'h1007},
        '{OP_RSVD_6,           8'h00, 1'b0, 1'b0, 8'd1,   1'b0, 16'h0000},
        '{OP_RSVD_7,           8'h00, 1'b0, 1'b0, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 8'd1,   1'b1, 16'h1007},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd13,  1'b0, 16'h0000},
        '{i2cbb_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd135, 1'b0, 16'h0000},
        '{i2cbb_pkg::OP_WRITE, 8'h00, 1'b1, 1'b1, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'hFF, 1'b1, 1'b1, 8'd135, 1'b0, 16'h0000},
        '{i2cbb_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 8'd89,  1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 8'd1,   1'b1, 16'h0FFA},
        '{i2cbb_pkg::OP_READ,  8'hFF, 1'b1, 1'b0, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd89,  1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd1,   1'b1, 16'h0008},
        '{i2cbb_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 8'd1,   1'b0, 16'h0000},
        '{i2cbb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 8'd10,  1'b0, 16'h0000}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // data_byte[7:0], send_ack[8], sda_in[9], zero pad
    logic [2:0]  s_tuser = '0;    // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // scl_level, sda_release, busy_res, done_res, read_byte, cmd_dropped
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // typed expectation travelling with the word on the input side
    logic        row_typed = 1'b0;
    logic [15:0] row_want = '0;

    // sequencer copy
    logic [15:0] delay_cfg = i2cbb_pkg::DELAY_RESET;
    logic [5:0]  seq_phase = '0;
    logic [1:0]  seq_cmd = i2cbb_pkg::CMD_START;
    logic [7:0]  seq_shift = '0;
    logic [15:0] seq_count = '0;
    logic        seq_ack = 1'b0;
    logic        scl_drv = 1'b1;
    logic        sda_drv = 1'b1;
    logic [7:0]  read_hold = '0;

    i2cbb_pkg::result_t pending_pins[$];

    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int sink_wait = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int done_count = 0;
    int drop_count = 0;

    i2c_bit_bang_master i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("timeout with %0d words still expected", pending_pins.size());
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 30)
            $display("%0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    function automatic logic [15:0] reload_count();
        return (delay_cfg == '0) ? 16'd1 : delay_cfg;
    endfunction

    // pin action number k of the running command
    task automatic apply_action(input logic [5:0] k, input logic line_in);
        logic [5:0] bitn;
        logic [5:0] sub;
        case (seq_cmd)
            i2cbb_pkg::CMD_START: begin
                if (k == 0) begin
                    sda_drv = 1'b1;
                    scl_drv = 1'b1;
                end else if (k == 1) begin
                    sda_drv = 1'b0;
                end else begin
                    scl_drv = 1'b0;
                end
            end
            i2cbb_pkg::CMD_STOP: begin
                if (k == 0) begin
                    sda_drv = 1'b0;
                    scl_drv = 1'b1;
                end else begin
                    sda_drv = 1'b1;
                end
            end
            i2cbb_pkg::CMD_WRITE: begin
                bitn = k / 3;
                sub  = k % 3;
                if (sub == 0) begin
                    if (bitn < 8) begin
                        sda_drv   = seq_shift[7];
                        seq_shift = {seq_shift[6:0], 1'b0};
                    end else begin
                        sda_drv = 1'b1;     // ack clock, line released
                    end
                end else if (sub == 1) begin
                    scl_drv = 1'b1;
                end else begin
                    scl_drv = 1'b0;
                end
            end
            default: begin
                bitn = k / 2;
                sub  = k % 2;
                if (sub == 0) begin
                    if (bitn < 8) begin
                        if (bitn == 0) sda_drv = 1'b1;
                        seq_shift = {seq_shift[6:0], line_in};
                    end else begin
                        sda_drv = ~seq_ack;
                    end
                    scl_drv = 1'b1;
                end else begin
                    scl_drv = 1'b0;
                end
            end
        endcase
    endtask

    task automatic predict_pins(input i2cbb_pkg::item_t it, output i2cbb_pkg::result_t r);
        logic       drop;
        logic       fin;
        logic [5:0] last_step;
        drop = 1'b0;
        fin  = 1'b0;
        if (it.op >= i2cbb_pkg::OP_START && it.op <= i2cbb_pkg::OP_READ) begin
            if (seq_phase != 0) begin
                drop = 1'b1;
                drop_count++;
            end else begin
                seq_cmd   = 2'(it.op - i2cbb_pkg::OP_START);
                seq_shift = (it.op == i2cbb_pkg::OP_WRITE) ? it.data_byte : 8'h00;
                seq_ack   = it.send_ack;
                apply_action(6'd0, it.sda_in);
                seq_phase = 6'd1;
                seq_count = reload_count();
            end
        end else if (seq_phase != 0) begin
            seq_count = seq_count - 16'd1;
            if (seq_count == 0) begin
                case (seq_cmd)
                    i2cbb_pkg::CMD_START: last_step = 6'd3;
                    i2cbb_pkg::CMD_STOP:  last_step = 6'd2;
                    i2cbb_pkg::CMD_WRITE: last_step = 6'd27;
                    default:              last_step = 6'd18;
                endcase
                if (seq_phase >= last_step) begin
                    if (seq_cmd == i2cbb_pkg::CMD_READ) read_hold = seq_shift;
                    seq_phase = '0;
                    fin = 1'b1;
                    done_count++;
                end else begin
                    apply_action(seq_phase, it.sda_in);
                    seq_phase = seq_phase + 6'd1;
                    seq_count = reload_count();
                end
            end
        end
        r.scl_level   = scl_drv;
        r.sda_release = sda_drv;
        r.busy_res    = (seq_phase != 0);
        r.done_res    = fin;
        r.read_byte   = read_hold;
        r.cmd_dropped = drop;
    endtask

    always @(posedge aclk) begin : watch_ports
        i2cbb_pkg::item_t   acc;
        i2cbb_pkg::result_t guess;
        i2cbb_pkg::result_t seen;
        i2cbb_pkg::result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) delay_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                acc.op        = s_tuser;
                acc.data_byte = s_tdata[7:0];
                acc.send_ack  = s_tdata[8];
                acc.sda_in    = s_tdata[9];
                predict_pins(acc, guess);
                pending_pins.push_back(row_typed ? i2cbb_pkg::result_t'(row_want[12:0])
                                                 : guess);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                words_out++;
                sink_wait = sink_gaps ? $urandom_range(0, 10) : 0;
                seen = i2cbb_pkg::result_t'(m_tdata[12:0]);
                if (pending_pins.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, '0);
                end else begin
                    want = pending_pins.pop_front();
                    check_field("scl_level", 16'(seen.scl_level), 16'(want.scl_level));
                    check_field("sda_release", 16'(seen.sda_release),
                                16'(want.sda_release));
                    check_field("busy_res", 16'(seen.busy_res), 16'(want.busy_res));
                    check_field("done_res", 16'(seen.done_res), 16'(want.done_res));
                    check_field("read_byte", 16'(seen.read_byte), 16'(want.read_byte));
                    check_field("cmd_dropped", 16'(seen.cmd_dropped),
                                16'(want.cmd_dropped));
                    check_field("tdata pad", 16'(m_tdata[15:13]), '0);
                end
            end
        end
    end

    // result side back-pressure, one draw per accepted word
    always @(negedge aclk) begin
        if (sink_wait > 0) begin
            m_tready  <= 1'b0;
            sink_wait = sink_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called and returns at a falling edge; tvalid stays high after the word
    task automatic send_word(input logic [2:0] op, input logic [7:0] data, input logic ack,
                             input logic line_in, input logic typed, input logic [15:0] want);
        int gap;
        gap = src_gaps ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {6'b0, line_in, ack, data};
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (pending_pins.size() != 0 && n < 3000) begin
            @(negedge aclk);
            n++;
        end
        if (pending_pins.size() != 0) begin
            report_mismatch("words never delivered", 16'(pending_pins.size()), '0);
            pending_pins.delete();
        end
    endtask

    // only with the sequencer idle and every word delivered
    task automatic set_delay(input logic [15:0] value);
        while (seq_phase != 0)
            send_word(i2cbb_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom),
                      1'b0, '0);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [2:0] tick_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return i2cbb_pkg::OP_TICK;
        return 3'(OP_RSVD_5 + (r - 7));
    endfunction

    // mostly whole commands run to completion, some refused commands and spare ops
    task automatic run_random(input int count);
        int         sent;
        int         n;
        int         r;
        logic [2:0] op;
        bit         is_cmd;
        sent = 0;
        n    = 0;
        while (sent < count) begin
            if (n % 64 == 0) begin
                src_gaps  = $urandom_range(0, 2) != 0;
                sink_gaps = $urandom_range(0, 2) != 0;
            end
            r = $urandom_range(0, 99);
            if (seq_phase == 0) is_cmd = (r < 85);
            else is_cmd = (r < 6);
            op = is_cmd ? 3'($urandom_range(i2cbb_pkg::OP_START, i2cbb_pkg::OP_READ))
                        : tick_op();
            if (is_cmd == (seq_phase == 0)) sent++;
            send_word(op, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            n++;
        end
    endtask

    initial begin
        logic [15:0] delays [5];
        delays = '{16'd1, 16'd0, 16'd2, 16'($urandom_range(3, 6)), 16'd1};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            for (int j = 0; j < stim_rows[i].reps; j++)
                send_word(stim_rows[i].op, stim_rows[i].data, stim_rows[i].ack,
                          stim_rows[i].sda, stim_rows[i].typed, stim_rows[i].want);
        end

        foreach (delays[i]) begin
            set_delay(delays[i]);
            run_random(250);
        end

        // longest delay unit: a stop left running with refused commands and a few ticks
        set_delay(16'hFFFF);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_word(i2cbb_pkg::OP_STOP, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        send_word(i2cbb_pkg::OP_WRITE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        send_word(i2cbb_pkg::OP_READ, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        send_word(i2cbb_pkg::OP_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        repeat (20)
            send_word(tick_op(), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (8) @(negedge aclk);

        $display("covered %0d words in, %0d out, %0d finished commands, %0d refused while busy",
                 words_in, words_out, done_count, drop_count);
        $display("delay units of reset value, 0, 1, 2, a small random value and 65535 ticks");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
